// ----- sv/hrdp_pkg.sv -----
// Package for the HID report descriptor parser: record, command and status types,
// item codes and default sizes. No dependencies.
`default_nettype none
package hrdp_pkg;

    localparam int DEF_MAX_REPORTS  = 8;
    localparam int DEF_MAX_FIELDS   = 32;
    localparam int DEF_MAX_USAGES   = 8;
    localparam int DEF_STACK_LEVELS = 4;

    localparam logic [7:0] LONG_PREFIX = 8'hFE;

    // Record kinds.
    localparam logic [2:0] K_FIELD   = 3'd0;
    localparam logic [2:0] K_REPORT  = 3'd1;
    localparam logic [2:0] K_END_OK  = 3'd2;
    localparam logic [2:0] K_END_INV = 3'd3;
    localparam logic [2:0] K_END_RES = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_NORES   = 2'd2;

    // Item types.
    localparam logic [1:0] TYP_MAIN   = 2'd0;
    localparam logic [1:0] TYP_GLOBAL = 2'd1;
    localparam logic [1:0] TYP_LOCAL  = 2'd2;

    // Global tags.
    localparam logic [3:0] TG_PAGE   = 4'd0;
    localparam logic [3:0] TG_LMIN   = 4'd1;
    localparam logic [3:0] TG_LMAX   = 4'd2;
    localparam logic [3:0] TG_RSIZE  = 4'd7;
    localparam logic [3:0] TG_RID    = 4'd8;
    localparam logic [3:0] TG_RCOUNT = 4'd9;
    localparam logic [3:0] TG_PUSH   = 4'd10;
    localparam logic [3:0] TG_POP    = 4'd11;

    // Local tags.
    localparam logic [3:0] TL_USAGE = 4'd0;
    localparam logic [3:0] TL_UMIN  = 4'd1;
    localparam logic [3:0] TL_UMAX  = 4'd2;

    // Main tags.
    localparam logic [3:0] TM_INPUT = 4'd8;
    localparam logic [3:0] TM_COLL  = 4'd10;
    localparam logic [3:0] TM_ECOLL = 4'd12;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_DATA,
        PH_LSIZE,
        PH_LTAG,
        PH_LSKIP
    } t_phase;

    typedef struct packed {
        logic [15:0] page;
        logic [31:0] lmin;
        logic [31:0] lmax;
        logic [15:0] rsize;
        logic [15:0] rcount;
        logic [7:0]  rid;
    } t_glob;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  rnum;
        logic [15:0] pos;
        logic [5:0]  width;
        logic [15:0] total;
        logic [15:0] flags;
        logic [15:0] page;
        logic [31:0] lmin;
        logic [31:0] lmax;
        logic [15:0] u0;
        logic [15:0] u1;
        logic        run_end;
    } t_rec;

    typedef struct packed {
        logic accept;
        logic find;
        logic check;
        logic urd;
        logic emit_field;
        logic emit_rpt;
        logic emit_end;
        logic rpt_init;
        logic clr_loc;
    } t_cmd;

    typedef struct packed {
        logic acc_input;
        logic byte_last;
        logic held_last;
        logic chk_emit;
        logic chk_var;
        logic elem_last;
        logic rpt_more;
        logic out_free;
    } t_sts;

    function automatic logic [2:0] item_len(input logic [7:0] pfx);
        return (pfx[1:0] == 2'd3) ? 3'd4 : {1'b0, pfx[1:0]};
    endfunction

    function automatic logic [31:0] sext(input logic [31:0] v, input logic [2:0] len);
        logic [31:0] r;
        r = v;
        if (len == 3'd1 && v[7]) begin
            r = {24'hFFFFFF, v[7:0]};
        end else if (len == 3'd2 && v[15]) begin
            r = {16'hFFFF, v[15:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/hid_report_descriptor_parser.sv -----
// HID report descriptor parser, top level. Prefix, data and skipped bytes are taken at intake.
// An Input item then goes through report lookup and checks, then emits the array field, or
// reads the usage list and emits for each Variable element, plus any output stall.
// The final byte is followed by one report record per report and then the end record.
// Reset is synchronous, active low, and clears all control state; the globals stack,
// usage list and report table are not cleared and are read only where written.
`default_nettype none
module hid_report_descriptor_parser #(
    parameter int MAX_REPORTS  = hrdp_pkg::DEF_MAX_REPORTS,
    parameter int MAX_FIELDS   = hrdp_pkg::DEF_MAX_FIELDS,
    parameter int MAX_USAGES   = hrdp_pkg::DEF_MAX_USAGES,
    parameter int STACK_LEVELS = hrdp_pkg::DEF_STACK_LEVELS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_desc_byte,
    input  logic               i_is_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_record_kind,
    output logic [7:0]         o_report_number,
    output logic [15:0]        o_bit_position,
    output logic [5:0]         o_bit_width,
    output logic [15:0]        o_element_total,
    output logic [15:0]        o_item_flags,
    output logic [15:0]        o_page_of_usage,
    output logic signed [31:0] o_min_logical,
    output logic signed [31:0] o_max_logical,
    output logic [15:0]        o_first_usage,
    output logic [15:0]        o_final_usage,
    output logic               o_run_end
);
    import hrdp_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_rec rec;

    hrdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hrdp_dp #(
        .MAX_REPORTS  (MAX_REPORTS),
        .MAX_FIELDS   (MAX_FIELDS),
        .MAX_USAGES   (MAX_USAGES),
        .STACK_LEVELS (STACK_LEVELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_desc_byte (i_desc_byte),
        .i_is_last   (i_is_last),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_rec       (rec)
    );

    assign o_record_kind   = rec.kind;
    assign o_report_number = rec.rnum;
    assign o_bit_position  = rec.pos;
    assign o_bit_width     = rec.width;
    assign o_element_total = rec.total;
    assign o_item_flags    = rec.flags;
    assign o_page_of_usage = rec.page;
    assign o_min_logical   = $signed(rec.lmin);
    assign o_max_logical   = $signed(rec.lmax);
    assign o_first_usage   = rec.u0;
    assign o_final_usage   = rec.u1;
    assign o_run_end       = rec.run_end;

endmodule
`default_nettype wire

// ----- sv/hrdp_ctrl.sv -----
// Sequencer of the HID report descriptor parser: steps through byte intake,
// report lookup, field emission and the closing report and end records. Uses hrdp_pkg.
`default_nettype none
module hrdp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hrdp_pkg::t_sts   i_sts,
    output hrdp_pkg::t_cmd   o_cmd
);
    import hrdp_pkg::*;

    typedef enum logic [2:0] {
        S_IN,
        S_FIND,
        S_CHECK,
        S_RD,
        S_EMIT,
        S_RPT,
        S_END
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IN: begin
                o_cmd.accept = i_in_valid & r_ready;
                if (i_in_valid && r_ready) begin
                    if (i_sts.acc_input) begin
                        n_state = S_FIND;
                    end else if (i_sts.byte_last) begin
                        n_state = S_RPT;
                        o_cmd.rpt_init = 1'b1;
                    end
                end
            end
            S_FIND: begin
                o_cmd.find = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.chk_emit) begin
                    n_state = i_sts.chk_var ? S_RD : S_EMIT;
                end else begin
                    o_cmd.clr_loc = 1'b1;
                    if (i_sts.held_last) begin
                        n_state = S_RPT;
                        o_cmd.rpt_init = 1'b1;
                    end else begin
                        n_state = S_IN;
                    end
                end
            end
            S_RD: begin
                o_cmd.urd = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_field = 1'b1;
                    if (i_sts.elem_last) begin
                        o_cmd.clr_loc = 1'b1;
                        if (i_sts.held_last) begin
                            n_state = S_RPT;
                            o_cmd.rpt_init = 1'b1;
                        end else begin
                            n_state = S_IN;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RPT: begin
                if (!i_sts.rpt_more) begin
                    n_state = S_END;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_rpt = 1'b1;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state = S_IN;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IN);
        end
    end

    assign o_in_ready = r_ready;

endmodule
`default_nettype wire

// ----- sv/hrdp_dp.sv -----
// Datapath of the HID report descriptor parser: item assembly, globals and their
// stack, local usages, report table and the output register. Uses hrdp_pkg.
`default_nettype none
module hrdp_dp #(
    parameter int MAX_REPORTS  = hrdp_pkg::DEF_MAX_REPORTS,
    parameter int MAX_FIELDS   = hrdp_pkg::DEF_MAX_FIELDS,
    parameter int MAX_USAGES   = hrdp_pkg::DEF_MAX_USAGES,
    parameter int STACK_LEVELS = hrdp_pkg::DEF_STACK_LEVELS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hrdp_pkg::t_cmd   i_cmd,
    output hrdp_pkg::t_sts   o_sts,
    input  logic [7:0]       i_desc_byte,
    input  logic             i_is_last,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output hrdp_pkg::t_rec   o_rec
);
    import hrdp_pkg::*;

    localparam int RCW = $clog2(MAX_REPORTS + 1);
    localparam int RIW = (MAX_REPORTS > 1) ? $clog2(MAX_REPORTS) : 1;
    localparam int FW  = $clog2(MAX_FIELDS + 1);
    localparam int UFW = $clog2(MAX_USAGES + 1);
    localparam int UIW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
    localparam int SFW = $clog2(STACK_LEVELS + 1);
    localparam int SIW = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;

    // Parse state.
    t_phase        r_phase, n_phase;
    logic [7:0]    r_held, n_held;
    logic [7:0]    r_pend, n_pend;
    logic [31:0]   r_gath, n_gath;
    t_glob         r_glob, n_glob;
    logic [SFW-1:0] r_sfill, n_sfill;
    logic [UFW-1:0] r_ufill, n_ufill;
    logic [15:0]   r_lastu, n_lastu;
    logic [15:0]   r_rmin, n_rmin, r_rmax, n_rmax;
    logic          r_rmin_ok, n_rmin_ok, r_rmax_ok, n_rmax_ok;
    logic [RCW-1:0] r_used, n_used;
    logic [FW-1:0] r_fused, n_fused;
    logic          r_ids, n_ids;
    logic [1:0]    r_err, n_err;
    logic          r_last, n_last;

    // Input item work registers.
    logic [RCW-1:0] r_rep, n_rep;
    logic          r_repok, n_repok;
    logic [31:0]   r_added, n_added;
    logic [15:0]   r_flags, n_flags;
    logic          r_var, n_var;
    logic [15:0]   r_pos, n_pos;
    logic [15:0]   r_elem, n_elem;
    logic [15:0]   r_urd;

    logic          r_ovalid, n_ovalid;
    t_rec          r_out, n_out;

    // Storage.
    t_glob         r_stack [STACK_LEVELS];
    logic [15:0]   r_ulist [MAX_USAGES];
    logic [7:0]    r_tid   [MAX_REPORTS];
    logic [15:0]   r_tbits [MAX_REPORTS];

    // Write strobes for storage.
    logic          push_we, ulist_we, tid_we, tbits_we;
    logic [15:0]   ulist_wd, tbits_wd;
    logic [RCW-1:0] tab_wa;

    // Item decode.
    logic          fire;
    logic [7:0]    pfx;
    logic [31:0]   val;
    logic [2:0]    len, ilen, shamt;
    logic [1:0]    ityp;
    logic [3:0]    itag;
    logic [SFW-1:0] sdec;

    // Input item helpers.
    logic          hit;
    logic [RCW-1:0] hidx;
    logic [15:0]   cur_bits;
    logic [31:0]   bits_sum;
    logic          bad, fits, fok;
    logic [15:0]   emitted;
    logic          elem_last;
    logic [16:0]   rsum;
    logic [15:0]   pick;

    assign cur_bits = r_tbits[r_rep[RIW-1:0]];
    assign bits_sum = {16'h0, cur_bits} + r_added;
    assign bad      = (r_glob.rsize > 16'd32) || (r_glob.rcount == 16'd0)
                      || (r_added > 32'h0000FFFF);
    assign fits     = (bits_sum <= 32'h0000FFFF);
    assign emitted  = r_var ? r_glob.rcount : 16'd1;
    assign fok      = ({1'b0, emitted} + 17'(r_fused)) <= 17'(MAX_FIELDS);
    assign elem_last = !r_var || (r_elem == (r_glob.rcount - 16'd1));
    assign rsum     = {1'b0, r_rmin} + {1'b0, r_elem};
    assign sdec     = r_sfill - SFW'(1);

    // Usage choice for one element of a variable field.
    always_comb begin
        if (r_elem < 16'(r_ufill)) begin
            pick = r_urd;
        end else if (r_rmin_ok && r_rmax_ok && rsum <= {1'b0, r_rmax}) begin
            pick = rsum[15:0];
        end else if (r_ufill != '0) begin
            pick = r_lastu;
        end else begin
            pick = 16'h0;
        end
    end

    always_comb begin
        hit  = 1'b0;
        hidx = '0;
        for (int i = 0; i < MAX_REPORTS; i++) begin
            if (!hit && RCW'(i) < r_used && r_tid[i] == r_glob.rid) begin
                hit  = 1'b1;
                hidx = RCW'(i);
            end
        end
    end

    always_comb begin
        n_phase = r_phase;   n_held = r_held;     n_pend = r_pend;
        n_gath = r_gath;     n_glob = r_glob;     n_sfill = r_sfill;
        n_ufill = r_ufill;   n_lastu = r_lastu;   n_rmin = r_rmin;
        n_rmax = r_rmax;     n_rmin_ok = r_rmin_ok; n_rmax_ok = r_rmax_ok;
        n_used = r_used;     n_fused = r_fused;   n_ids = r_ids;
        n_err = r_err;       n_last = r_last;     n_rep = r_rep;
        n_repok = r_repok;   n_added = r_added;   n_flags = r_flags;
        n_var = r_var;       n_pos = r_pos;       n_elem = r_elem;
        n_out = r_out;
        n_ovalid = i_out_ready ? 1'b0 : r_ovalid;
        push_we = 1'b0;  ulist_we = 1'b0;  tid_we = 1'b0;  tbits_we = 1'b0;
        ulist_wd = '0;   tbits_wd = '0;    tab_wa = r_rep;
        fire = 1'b0;  pfx = 8'h0;  val = 32'h0;  len = 3'd0;  shamt = 3'd0;
        o_sts = '0;

        // Byte intake.
        if (i_cmd.accept) begin
            n_last = i_is_last;
            if (r_err == ERR_NONE) begin
                unique case (r_phase)
                    PH_PREFIX: begin
                        if (i_desc_byte == LONG_PREFIX) begin
                            n_phase = PH_LSIZE;
                        end else begin
                            n_held = i_desc_byte;
                            n_gath = 32'h0;
                            if (item_len(i_desc_byte) == 3'd0) begin
                                fire = 1'b1;
                                pfx  = i_desc_byte;
                            end else begin
                                n_pend  = {5'b0, item_len(i_desc_byte)};
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        len = item_len(r_held);
                        if (r_pend == 8'd0 || r_pend > {5'b0, len}) begin
                            n_phase = PH_PREFIX;
                        end else begin
                            shamt  = len - r_pend[2:0];
                            n_gath = r_gath | ({24'h0, i_desc_byte} << {shamt, 3'b000});
                            n_pend = r_pend - 8'd1;
                            if (n_pend == 8'd0) begin
                                n_phase = PH_PREFIX;
                                fire = 1'b1;
                                pfx  = r_held;
                                val  = n_gath;
                            end
                        end
                    end
                    PH_LSIZE: begin
                        n_pend  = i_desc_byte;
                        n_phase = PH_LTAG;
                    end
                    PH_LTAG: begin
                        n_phase = (r_pend == 8'd0) ? PH_PREFIX : PH_LSKIP;
                    end
                    default: begin
                        if (r_pend != 8'd0) begin
                            n_pend = r_pend - 8'd1;
                        end
                        if (n_pend == 8'd0) begin
                            n_phase = PH_PREFIX;
                        end
                    end
                endcase
            end
        end

        ilen = item_len(pfx);
        ityp = pfx[3:2];
        itag = pfx[7:4];
        if (fire) begin
            if (ityp == TYP_GLOBAL) begin
                case (itag)
                    TG_PAGE:   n_glob.page = val[15:0];
                    TG_LMIN:   n_glob.lmin = sext(val, ilen);
                    TG_LMAX:   n_glob.lmax = r_glob.lmin[31] ? sext(val, ilen) : val;
                    TG_RSIZE:  n_glob.rsize = val[15:0];
                    TG_RID: begin
                        if (val == 32'h0 || val > 32'd255) begin
                            n_err = ERR_INVALID;
                        end else begin
                            n_glob.rid = val[7:0];
                            n_ids = 1'b1;
                        end
                    end
                    TG_RCOUNT: n_glob.rcount = val[15:0];
                    TG_PUSH: begin
                        if (r_sfill >= SFW'(STACK_LEVELS)) begin
                            n_err = ERR_NORES;
                        end else begin
                            push_we = 1'b1;
                            n_sfill = r_sfill + SFW'(1);
                        end
                    end
                    TG_POP: begin
                        if (r_sfill == '0) begin
                            n_err = ERR_INVALID;
                        end else begin
                            n_glob  = r_stack[sdec[SIW-1:0]];
                            n_sfill = sdec;
                        end
                    end
                    default: ;
                endcase
            end else if (ityp == TYP_LOCAL) begin
                if (itag == TL_USAGE) begin
                    if (r_ufill < UFW'(MAX_USAGES)) begin
                        ulist_we = 1'b1;
                        ulist_wd = val[15:0];
                        n_lastu  = val[15:0];
                        n_ufill  = r_ufill + UFW'(1);
                    end
                end else if (itag == TL_UMIN) begin
                    n_rmin = val[15:0];
                    n_rmin_ok = 1'b1;
                end else if (itag == TL_UMAX) begin
                    n_rmax = val[15:0];
                    n_rmax_ok = 1'b1;
                end
            end else if (ityp == TYP_MAIN) begin
                if (itag == TM_INPUT) begin
                    // Locals stay until the Input item has been worked off.
                    o_sts.acc_input = 1'b1;
                    n_flags = val[15:0];
                    n_var   = val[1];
                end else begin
                    if (itag == TM_ECOLL && ilen != 3'd0) begin
                        n_err = ERR_INVALID;
                    end else if (itag == TM_COLL && ilen != 3'd1) begin
                        n_err = ERR_INVALID;
                    end
                    n_ufill = '0;
                    n_rmin = 16'h0;  n_rmax = 16'h0;
                    n_rmin_ok = 1'b0; n_rmax_ok = 1'b0;
                end
            end
        end

        // A final byte that leaves an item open is a truncated descriptor.
        if (i_cmd.accept && i_is_last && n_err == ERR_NONE && n_phase != PH_PREFIX) begin
            n_err = ERR_INVALID;
        end

        if (i_cmd.find) begin
            n_added = r_glob.rsize * r_glob.rcount;
            if (hit) begin
                n_rep   = hidx;
                n_repok = 1'b1;
            end else if (r_used < RCW'(MAX_REPORTS)) begin
                tid_we   = 1'b1;
                tbits_we = 1'b1;
                tab_wa   = r_used;
                tbits_wd = 16'h0;
                n_rep    = r_used;
                n_repok  = 1'b1;
                n_used   = r_used + RCW'(1);
            end else begin
                n_repok = 1'b0;
            end
        end

        if (i_cmd.check) begin
            if (bad) begin
                n_err = ERR_INVALID;
            end else if (r_repok && fits) begin
                tbits_we = 1'b1;
                tbits_wd = bits_sum[15:0];
            end
            n_pos  = cur_bits;
            n_elem = 16'h0;
        end

        if (i_cmd.emit_field) begin
            n_ovalid      = 1'b1;
            n_out.kind    = K_FIELD;
            n_out.rnum    = r_glob.rid;
            n_out.pos     = r_pos;
            n_out.width   = r_glob.rsize[5:0];
            n_out.total   = r_var ? 16'd1 : r_glob.rcount;
            n_out.flags   = r_flags;
            n_out.page    = r_glob.page;
            n_out.lmin    = r_glob.lmin;
            n_out.lmax    = r_glob.lmax;
            n_out.u0      = r_var ? pick : (r_rmin_ok ? r_rmin : 16'h0);
            n_out.u1      = r_var ? pick : (r_rmax_ok ? r_rmax : 16'hFFFF);
            n_out.run_end = elem_last && !r_last;
            n_pos   = r_pos + r_glob.rsize;
            n_elem  = r_elem + 16'd1;
            n_fused = r_fused + FW'(1);
        end

        if (i_cmd.clr_loc) begin
            n_ufill = '0;
            n_rmin = 16'h0;  n_rmax = 16'h0;
            n_rmin_ok = 1'b0; n_rmax_ok = 1'b0;
        end

        if (i_cmd.rpt_init) begin
            n_rep = '0;
        end

        if (i_cmd.emit_rpt) begin
            n_ovalid = 1'b1;
            n_out    = '0;
            n_out.kind = K_REPORT;
            n_out.rnum = r_tid[r_rep[RIW-1:0]];
            n_out.pos  = cur_bits;
            n_rep = r_rep + RCW'(1);
        end

        if (i_cmd.emit_end) begin
            n_ovalid = 1'b1;
            n_out    = '0;
            if (r_err == ERR_INVALID) begin
                n_out.kind = K_END_INV;
            end else if (r_err == ERR_NORES) begin
                n_out.kind = K_END_RES;
            end else begin
                n_out.kind = (r_used == '0) ? K_END_INV : K_END_OK;
            end
            n_out.rnum    = {7'h0, r_ids};
            n_out.run_end = 1'b1;
            // Back to the state after reset for the next descriptor.
            n_phase = PH_PREFIX;  n_held = 8'h0;  n_pend = 8'h0;  n_gath = 32'h0;
            n_glob = '0;          n_sfill = '0;   n_ufill = '0;
            n_rmin = 16'h0;       n_rmax = 16'h0;
            n_rmin_ok = 1'b0;     n_rmax_ok = 1'b0;
            n_used = '0;          n_fused = '0;   n_ids = 1'b0;
            n_err = ERR_NONE;     n_last = 1'b0;
        end

        o_sts.byte_last = i_is_last;
        o_sts.held_last = r_last;
        o_sts.chk_emit  = !bad && r_repok && fits && fok;
        o_sts.chk_var   = r_var;
        o_sts.elem_last = elem_last;
        o_sts.rpt_more  = (r_rep < r_used);
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_held <= 8'h0;
            r_pend <= 8'h0;
            r_gath <= 32'h0;
            r_glob <= '0;
            r_sfill <= '0;
            r_ufill <= '0;
            r_rmin <= 16'h0;
            r_rmax <= 16'h0;
            r_rmin_ok <= 1'b0;
            r_rmax_ok <= 1'b0;
            r_used <= '0;
            r_fused <= '0;
            r_ids <= 1'b0;
            r_err <= ERR_NONE;
            r_last <= 1'b0;
            r_repok <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_held <= n_held;
            r_pend <= n_pend;
            r_gath <= n_gath;
            r_glob <= n_glob;
            r_sfill <= n_sfill;
            r_ufill <= n_ufill;
            r_rmin <= n_rmin;
            r_rmax <= n_rmax;
            r_rmin_ok <= n_rmin_ok;
            r_rmax_ok <= n_rmax_ok;
            r_used <= n_used;
            r_fused <= n_fused;
            r_ids <= n_ids;
            r_err <= n_err;
            r_last <= n_last;
            r_repok <= n_repok;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lastu <= n_lastu;
        r_rep   <= n_rep;
        r_added <= n_added;
        r_flags <= n_flags;
        r_var   <= n_var;
        r_pos   <= n_pos;
        r_elem  <= n_elem;
        r_out   <= n_out;
        if (push_we) begin
            r_stack[r_sfill[SIW-1:0]] <= r_glob;
        end
        if (ulist_we) begin
            r_ulist[r_ufill[UIW-1:0]] <= ulist_wd;
        end
        if (i_cmd.urd) begin
            r_urd <= r_ulist[r_elem[UIW-1:0]];
        end
        if (tid_we) begin
            r_tid[tab_wa[RIW-1:0]] <= r_glob.rid;
        end
        if (tbits_we) begin
            r_tbits[tab_wa[RIW-1:0]] <= tbits_wd;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_rec       = r_out;

    a_fields_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fused <= FW'(MAX_FIELDS))
        else $error("field count passed its limit");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sfill <= SFW'(STACK_LEVELS))
        else $error("globals stack overfilled");

    a_reports_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= RCW'(MAX_REPORTS))
        else $error("report table overfilled");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && (r_out.kind == K_END_OK || r_out.kind == K_END_INV
                      || r_out.kind == K_END_RES)) |-> r_out.run_end)
        else $error("end record without run end mark");

endmodule
`default_nettype wire
